// ===== rtl/core/qsv_pkg.sv =====
// Shared constants, types and arithmetic helpers of the state-vector gate engine.
package qsv_pkg;

	localparam int STATE_DEPTH = 1024;
	localparam int FRAC_BITS = 30;
	localparam int AW = $clog2(STATE_DEPTH);
	localparam int MAXQ = AW;
	localparam int QW = 4;
	localparam int CW = 3;
	localparam int DW = 32;
	localparam int EW = 2 * DW;
	localparam int ACW = EW + 2;

	typedef logic [AW-1:0] addr_t;
	typedef logic [EW-1:0] amp_t;

	typedef enum logic [CW-1:0] {
		CMD_INIT    = 3'd0,
		CMD_GATE    = 3'd1,
		CMD_CNOT    = 3'd2,
		CMD_QUERY   = 3'd3,
		CMD_MEASURE = 3'd4
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic clear;
		logic negate;
		logic last;
	} mac_ctrl_t;

	localparam amp_t AMP_ONE = EW'(1) << (FRAC_BITS + DW);
	localparam logic signed [ACW-1:0] RND_HALF = ACW'(1) << (FRAC_BITS - 1);
	localparam logic signed [ACW-1:0] SAT_HI = ACW'(33'sh0_7FFF_FFFF);
	localparam logic signed [ACW-1:0] SAT_LO = -(ACW'(1) << (DW - 1));

	function automatic logic [DW-1:0] round_sat(input logic signed [ACW-1:0] acc);
		logic signed [ACW-1:0] sum;
		logic signed [ACW-1:0] r;
		sum = acc + RND_HALF;
		r = sum >>> FRAC_BITS;
		if (r > SAT_HI) begin
			return 32'h7FFF_FFFF;
		end else if (r < SAT_LO) begin
			return 32'h8000_0000;
		end
		return r[DW-1:0];
	endfunction

endpackage

// ===== rtl/core/qsv_amp_ram.sv =====
// Amplitude memory: one write port and one registered read port.
module qsv_amp_ram (
	input  logic                clk,
	input  logic                we,
	input  qsv_pkg::addr_t      waddr,
	input  qsv_pkg::amp_t       wdata,
	input  qsv_pkg::addr_t      raddr,
	output qsv_pkg::amp_t       rdata
);
	import qsv_pkg::*;

	amp_t mem [STATE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/qsv_mac.sv =====
// Registered signed multiplier followed by an accumulator for the gate and probability sums.
module qsv_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  qsv_pkg::mac_ctrl_t            ctrl,
	input  logic signed [qsv_pkg::DW-1:0] op_a,
	input  logic signed [qsv_pkg::DW-1:0] op_b,
	output logic signed [qsv_pkg::ACW-1:0] acc,
	output logic                          done
);
	import qsv_pkg::*;

	mac_ctrl_t ctrl_s1;
	logic signed [EW-1:0] prod_s1;
	logic signed [ACW-1:0] acc_q;
	logic signed [ACW-1:0] term;
	logic done_q;

	assign term = ctrl_s1.negate ? -$signed({{2{prod_s1[EW-1]}}, prod_s1})
	                             : $signed({{2{prod_s1[EW-1]}}, prod_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			done_q <= 1'b0;
		end else begin
			ctrl_s1 <= ctrl;
			done_q <= ctrl_s1.valid & ctrl_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		if (ctrl_s1.valid) begin
			acc_q <= (ctrl_s1.clear ? '0 : acc_q) + term;
		end
	end

	assign acc = acc_q;
	assign done = done_q;

endmodule

// ===== rtl/core/qsv_div.sv =====
// Restoring divider that produces the rescaled magnitude, one quotient bit per cycle.
module qsv_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  qsv_pkg::amp_t         dividend,
	input  logic [qsv_pkg::DW-1:0] divisor,
	output logic                  busy,
	output logic                  done,
	output logic [qsv_pkg::DW-1:0] quotient
);
	import qsv_pkg::*;

	localparam int QB = DW + 1;
	localparam int CNTW = $clog2(QB + 1);

	logic [DW-1:0] rem_q;
	logic [QB-1:0] dvd_q;
	logic [QB-1:0] quo_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0] dsr_q;
	logic busy_q;
	logic done_q;
	logic ovf_q;
	logic [QB-1:0] trial;
	logic [QB-1:0] diff;
	logic fits;
	logic [EW-QB-1:0] head;

	assign head = dividend[EW-1:QB];
	assign trial = {rem_q, dvd_q[QB-1]};
	assign fits = trial >= {1'b0, dsr_q};
	assign diff = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q <= 1'b0;
			cnt_q <= '0;
			rem_q <= '0;
			dvd_q <= '0;
			quo_q <= '0;
			dsr_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dsr_q <= divisor;
				quo_q <= '0;
				if (DW'(head) >= divisor) begin
					ovf_q <= 1'b1;
					done_q <= 1'b1;
				end else begin
					ovf_q <= 1'b0;
					busy_q <= 1'b1;
					rem_q <= DW'(head);
					dvd_q <= dividend[QB-1:0];
					cnt_q <= CNTW'(QB);
				end
			end else if (busy_q) begin
				rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
				dvd_q <= dvd_q << 1;
				quo_q <= {quo_q[QB-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (ovf_q || quo_q > QB'(33'h0_8000_0000)) begin
			quotient = 32'h8000_0000;
		end else begin
			quotient = quo_q[DW-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

// ===== rtl/core/qsv_isqrt.sv =====
// Digit-by-digit integer square root, two radicand bits per cycle.
module qsv_isqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  qsv_pkg::amp_t          radicand,
	output logic                   busy,
	output logic                   done,
	output logic [qsv_pkg::DW-1:0] root
);
	import qsv_pkg::*;

	amp_t v_q;
	amp_t r_q;
	amp_t bit_q;
	amp_t rb;
	logic busy_q;
	logic done_q;

	assign rb = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			r_q <= '0;
			bit_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				v_q <= radicand;
				r_q <= '0;
				bit_q <= EW'(1) << (EW - 2);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (v_q >= rb) begin
					v_q <= v_q - rb;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q == EW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign root = r_q[DW-1:0];
	assign busy = busy_q;
	assign done = done_q;

endmodule

// ===== rtl/core/qubit_state_vector_gate_engine_core.sv =====
// Top level of the state-vector gate engine: command sequencer around the amplitude memory.
//
// The host writes the qubit count on the cfg channel (taken in any cycle) and sends one
// command word on the in channel; each command returns exactly one word on the out channel.
// The amplitudes live in one memory of 1024 entries with a registered read port; every
// command works through it one entry pair at a time, so n below is the active qubit count.
// What each command word does from acceptance to result ready, each ending in the done state:
//   init: a write pass over the whole memory
//   gate: 2^(n-1) pairs; one shared 32x32 multiplier does 16 products per pair
//   controlled-not: pairs with the control bit set are read and swapped, others only read
//   query: two squares per entry through the same multiplier
//   measure: query, then the square root, then for each pair every nonzero kept
//   amplitude half goes through a bit-serial divider
//   bad target or unknown command: straight to the result
// After reset the block runs the init pass with in_ready low.
// The result sits in an output register; the next command word is accepted while it
// waits. If the receiver stalls, a finished command holds the sequencer until the output
// register frees up.
module qubit_state_vector_gate_engine_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [qsv_pkg::QW-1:0]        active_qubits,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [qsv_pkg::CW-1:0]        cmd,
	input  logic [qsv_pkg::QW-1:0]        target_qubit,
	input  logic [qsv_pkg::QW-1:0]        control_qubit,
	input  logic signed [qsv_pkg::DW-1:0] m00_re,
	input  logic signed [qsv_pkg::DW-1:0] m00_im,
	input  logic signed [qsv_pkg::DW-1:0] m01_re,
	input  logic signed [qsv_pkg::DW-1:0] m01_im,
	input  logic signed [qsv_pkg::DW-1:0] m10_re,
	input  logic signed [qsv_pkg::DW-1:0] m10_im,
	input  logic signed [qsv_pkg::DW-1:0] m11_re,
	input  logic signed [qsv_pkg::DW-1:0] m11_im,
	input  logic [qsv_pkg::DW-1:0]        random_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          outcome,
	output logic [qsv_pkg::DW-1:0]        prob_one
);
	import qsv_pkg::*;

	localparam int PSH = (2 * FRAC_BITS >= DW) ? 2 * FRAC_BITS - DW : 0;
	localparam int PSL = (2 * FRAC_BITS >= DW) ? 0 : DW - 2 * FRAC_BITS;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_RD_A, S_RD_B, S_GOT_B, S_MAC, S_MAC_WAIT, S_SC_START,
		S_SC_DIV, S_WR_A, S_WR_B, S_P_RD, S_P_GOT, S_P_SQ1, S_P_SQ2, S_P_WAIT,
		S_P_END, S_SQRT, S_DONE
	} state_t;

	state_t state_q;
	logic [QW-1:0] active_q;
	logic [CW-1:0] op_q;
	logic [QW-1:0] tq_q;
	logic [QW-1:0] cq_q;
	logic signed [DW-1:0] m_q [8];
	logic [DW-1:0] rnd_q;
	logic reply_q;
	addr_t clr_q;
	logic [AW-2:0] pc_q;
	amp_t a_q;
	amp_t b_q;
	logic [3:0] mop_q;
	logic [1:0] gcnt_q;
	logic [DW-1:0] gres_q [4];
	logic [EW-1:0] prob_sum_q;
	logic oc_q;
	logic [DW-1:0] s_q;
	logic h_q;
	logic [DW-1:0] sc_q [2];
	logic res_outcome_q;
	logic [DW-1:0] res_prob_q;
	logic out_valid_q;
	logic outcome_q;
	logic [DW-1:0] prob_q;

	logic [QW-1:0] n_eff;
	addr_t dim_mask;
	addr_t tmask;
	addr_t cmask;
	addr_t low_mask;
	addr_t pc_ext;
	addr_t pair_i;
	addr_t pair_j;
	logic pair_last;
	logic ctl_set;

	logic mem_we;
	addr_t mem_waddr;
	amp_t mem_wdata;
	addr_t mem_raddr;
	amp_t mem_rdata;

	mac_ctrl_t mac_ctrl;
	logic signed [DW-1:0] mac_a;
	logic signed [DW-1:0] mac_b;
	logic signed [ACW-1:0] mac_acc;
	logic mac_done;
	logic [1:0] mop_t;
	logic [1:0] mop_o;
	logic [2:0] m_idx;

	logic [EW:0] prob_add;
	logic [EW-1:0] prob_wide;
	logic [DW-1:0] p_val;
	logic oc_now;
	logic [DW:0] kept;

	amp_t sc_src;
	logic [DW-1:0] half;
	logic [DW-1:0] half_mag;
	logic div_start;
	logic div_busy;
	logic div_done;
	logic [DW-1:0] div_q;
	amp_t div_dividend;
	logic [DW-1:0] sc_val;

	logic sqrt_start;
	logic sqrt_busy;
	logic sqrt_done;
	logic [DW-1:0] sqrt_root;
	logic load_out;

	// Address generation for the pair (i, i with the target bit set).
	always_comb begin
		if (active_q == '0) begin
			n_eff = QW'(1);
		end else if (active_q > QW'(MAXQ)) begin
			n_eff = QW'(MAXQ);
		end else begin
			n_eff = active_q;
		end
		dim_mask = ~({AW{1'b1}} << n_eff);
		tmask = AW'(1) << tq_q;
		cmask = AW'(1) << cq_q;
		low_mask = ~({AW{1'b1}} << tq_q);
		pc_ext = {1'b0, pc_q};
		pair_i = ((pc_ext & ~low_mask) << 1) | (pc_ext & low_mask);
		pair_j = pair_i | tmask;
		pair_last = (pc_q == dim_mask[AW-1:1]);
		ctl_set = |(pair_i & cmask);
	end

	// Multiplier operand selection.
	always_comb begin
		mop_t = mop_q[1:0];
		mop_o = mop_q[3:2];
		m_idx = {mop_o[1], mop_t[1], mop_t[0] ^ mop_o[0]};
		mac_ctrl = '0;
		mac_a = m_q[m_idx];
		case (mop_t)
			2'd0: mac_b = a_q[EW-1:DW];
			2'd1: mac_b = a_q[DW-1:0];
			2'd2: mac_b = b_q[EW-1:DW];
			default: mac_b = b_q[DW-1:0];
		endcase
		case (state_q)
			S_MAC: begin
				mac_ctrl.valid = 1'b1;
				mac_ctrl.clear = (mop_t == 2'd0);
				mac_ctrl.negate = ~mop_o[0] & mop_t[0];
				mac_ctrl.last = (mop_t == 2'd3);
			end
			S_P_SQ1: begin
				mac_ctrl.valid = 1'b1;
				mac_ctrl.clear = 1'b1;
				mac_a = b_q[EW-1:DW];
				mac_b = b_q[EW-1:DW];
			end
			S_P_SQ2: begin
				mac_ctrl.valid = 1'b1;
				mac_ctrl.last = 1'b1;
				mac_a = b_q[DW-1:0];
				mac_b = b_q[DW-1:0];
			end
			default: begin
			end
		endcase
	end

	// Probability of one and the measurement decision.
	always_comb begin
		prob_add = {1'b0, prob_sum_q} + {1'b0, mac_acc[EW-1:0]};
		if (2 * FRAC_BITS >= DW) begin
			prob_wide = prob_sum_q >> PSH;
		end else if (prob_sum_q > ({EW{1'b1}} >> PSL)) begin
			prob_wide = '1;
		end else begin
			prob_wide = prob_sum_q << PSL;
		end
		p_val = (|prob_wide[EW-1:DW]) ? '1 : prob_wide[DW-1:0];
		oc_now = !(rnd_q > p_val);
		kept = oc_now ? {1'b0, p_val} : (33'h1_0000_0000 - {1'b0, p_val});
	end

	// Rescale of the kept amplitude halves.
	always_comb begin
		sc_src = oc_q ? b_q : a_q;
		half = h_q ? sc_src[DW-1:0] : sc_src[EW-1:DW];
		half_mag = half[DW-1] ? -half : half;
		div_dividend = ({{DW{1'b0}}, half_mag} << (DW - 1)) + EW'(s_q >> 1);
		div_start = (state_q == S_SC_START) && (half != '0) && (s_q != '0);
		if (half[DW-1]) begin
			sc_val = -div_q;
		end else if (div_q[DW-1]) begin
			sc_val = 32'h7FFF_FFFF;
		end else begin
			sc_val = div_q;
		end
		sqrt_start = (state_q == S_P_END) && (op_q == CMD_MEASURE);
	end

	// Memory port control.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = pair_i;
		mem_wdata = '0;
		mem_raddr = (state_q == S_RD_A) ? pair_i : pair_j;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = (clr_q == '0) ? AMP_ONE : '0;
			end
			S_WR_A: begin
				mem_we = 1'b1;
				if (op_q == CMD_GATE) begin
					mem_wdata = {gres_q[0], gres_q[1]};
				end else if (op_q == CMD_CNOT) begin
					mem_wdata = b_q;
				end else begin
					mem_wdata = oc_q ? '0 : {sc_q[0], sc_q[1]};
				end
			end
			S_WR_B: begin
				mem_we = 1'b1;
				mem_waddr = pair_j;
				if (op_q == CMD_GATE) begin
					mem_wdata = {gres_q[2], gres_q[3]};
				end else if (op_q == CMD_CNOT) begin
					mem_wdata = a_q;
				end else begin
					mem_wdata = oc_q ? {sc_q[0], sc_q[1]} : '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			active_q <= QW'(10);
			op_q <= '0;
			tq_q <= '0;
			cq_q <= '0;
			for (int k = 0; k < 8; k++) begin
				m_q[k] <= '0;
			end
			rnd_q <= '0;
			reply_q <= 1'b0;
			clr_q <= '0;
			pc_q <= '0;
			a_q <= '0;
			b_q <= '0;
			mop_q <= '0;
			gcnt_q <= '0;
			for (int k = 0; k < 4; k++) begin
				gres_q[k] <= '0;
			end
			prob_sum_q <= '0;
			oc_q <= 1'b0;
			s_q <= '0;
			h_q <= 1'b0;
			sc_q[0] <= '0;
			sc_q[1] <= '0;
			res_outcome_q <= 1'b0;
			res_prob_q <= '0;
			out_valid_q <= 1'b0;
			outcome_q <= 1'b0;
			prob_q <= '0;
		end else begin
			if (cfg_valid) begin
				active_q <= active_qubits;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (mac_done && op_q == CMD_GATE) begin
				gres_q[gcnt_q] <= round_sat(mac_acc);
				gcnt_q <= gcnt_q + 1'b1;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {AW{1'b1}}) begin
						state_q <= reply_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q <= cmd;
						tq_q <= target_qubit;
						cq_q <= control_qubit;
						m_q[0] <= m00_re;
						m_q[1] <= m00_im;
						m_q[2] <= m01_re;
						m_q[3] <= m01_im;
						m_q[4] <= m10_re;
						m_q[5] <= m10_im;
						m_q[6] <= m11_re;
						m_q[7] <= m11_im;
						rnd_q <= random_value;
						res_outcome_q <= 1'b0;
						res_prob_q <= '0;
						pc_q <= '0;
						gcnt_q <= '0;
						prob_sum_q <= '0;
						case (cmd)
							CMD_INIT: begin
								clr_q <= '0;
								reply_q <= 1'b1;
								state_q <= S_CLEAR;
							end
							CMD_GATE: begin
								state_q <= (target_qubit >= n_eff) ? S_DONE : S_RD_A;
							end
							CMD_CNOT: begin
								if (target_qubit >= n_eff || control_qubit >= n_eff ||
								    control_qubit == target_qubit) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_RD_A;
								end
							end
							CMD_QUERY, CMD_MEASURE: begin
								state_q <= (target_qubit >= n_eff) ? S_DONE : S_P_RD;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_RD_A: begin
					state_q <= S_RD_B;
				end
				S_RD_B: begin
					a_q <= mem_rdata;
					state_q <= S_GOT_B;
				end
				S_GOT_B: begin
					b_q <= mem_rdata;
					h_q <= 1'b0;
					mop_q <= '0;
					if (op_q == CMD_GATE) begin
						state_q <= S_MAC;
					end else if (op_q == CMD_CNOT) begin
						if (ctl_set) begin
							state_q <= S_WR_A;
						end else if (pair_last) begin
							state_q <= S_DONE;
						end else begin
							pc_q <= pc_q + 1'b1;
							state_q <= S_RD_A;
						end
					end else begin
						state_q <= S_SC_START;
					end
				end
				S_MAC: begin
					mop_q <= mop_q + 1'b1;
					if (mop_q == 4'hF) begin
						state_q <= S_MAC_WAIT;
					end
				end
				S_MAC_WAIT: begin
					if (mac_done && gcnt_q == 2'd3) begin
						state_q <= S_WR_A;
					end
				end
				S_SC_START: begin
					if (!div_start) begin
						sc_q[h_q] <= (half == '0) ? '0 :
						             (half[DW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
						h_q <= 1'b1;
						if (h_q) begin
							state_q <= S_WR_A;
						end
					end else begin
						state_q <= S_SC_DIV;
					end
				end
				S_SC_DIV: begin
					if (div_done) begin
						sc_q[h_q] <= sc_val;
						h_q <= 1'b1;
						state_q <= h_q ? S_WR_A : S_SC_START;
					end
				end
				S_WR_A: begin
					state_q <= S_WR_B;
				end
				S_WR_B: begin
					if (pair_last) begin
						state_q <= S_DONE;
					end else begin
						pc_q <= pc_q + 1'b1;
						state_q <= S_RD_A;
					end
				end
				S_P_RD: begin
					state_q <= S_P_GOT;
				end
				S_P_GOT: begin
					b_q <= mem_rdata;
					state_q <= S_P_SQ1;
				end
				S_P_SQ1: begin
					state_q <= S_P_SQ2;
				end
				S_P_SQ2: begin
					state_q <= S_P_WAIT;
				end
				S_P_WAIT: begin
					if (mac_done) begin
						prob_sum_q <= prob_add[EW] ? '1 : prob_add[EW-1:0];
						if (pair_last) begin
							state_q <= S_P_END;
						end else begin
							pc_q <= pc_q + 1'b1;
							state_q <= S_P_RD;
						end
					end
				end
				S_P_END: begin
					res_prob_q <= p_val;
					if (op_q == CMD_MEASURE) begin
						res_outcome_q <= oc_now;
						oc_q <= oc_now;
						pc_q <= '0;
						state_q <= S_SQRT;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						s_q <= sqrt_root;
						state_q <= S_RD_A;
					end
				end
				S_DONE: begin
					if (load_out) begin
						outcome_q <= res_outcome_q;
						prob_q <= res_prob_q;
						reply_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	qsv_amp_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	qsv_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.op_a   (mac_a),
		.op_b   (mac_b),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	qsv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (s_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	qsv_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand ({kept, 31'b0} >> 1),
		.busy     (sqrt_busy),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign outcome = outcome_q;
	assign prob_one = prob_q;

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !mem_we)
		else $error("Amplitude memory written while the sequencer is idle.");

	a_idle_units_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !mac_done && !div_busy && !sqrt_busy)
		else $error("Arithmetic unit still active while a new word can be accepted.");

	a_pair_base: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD_A |-> (pair_i & tmask) == '0)
		else $error("Pair base index has the target bit set.");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q && state_q == S_IDLE)
		else $error("Finished command did not reach the output register.");

endmodule
